// ===== hdl/rrmf_pkg.sv =====
// ----------------------------------------------------------------------------
// rrmf_pkg
// Shared types and constants of the record marking framer.
// ----------------------------------------------------------------------------
`default_nettype none

package rrmf_pkg;

    // Positions in the fragment buffer; the capacity register is 9 bits wide,
    // so no position ever exceeds 511.
    localparam int unsigned POS_W = 9;
    localparam int unsigned CFG_W = 9;

    typedef logic [POS_W-1:0] t_pos;
    typedef logic [2:0]       t_cnt;

    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;
    localparam t_pos             HDR_BYTES = 9'd4;
    localparam t_pos             CAP_MIN   = 9'd8;
    localparam t_cnt             WORD_BYTES = 3'd4;

    localparam logic [1:0] REQ_PUT_UNIT  = 2'd0;
    localparam logic [1:0] REQ_PUT_BYTES = 2'd1;
    localparam logic [1:0] REQ_END_BUF   = 2'd2;
    localparam logic [1:0] REQ_END_NOW   = 2'd3;

    // Record mark flag: final fragment of a record, or more to follow.
    localparam logic MARK_LAST = 1'b1;
    localparam logic MARK_MORE = 1'b0;

    localparam int unsigned CMDQ_DEPTH = 4;
    localparam int unsigned OQ_DEPTH   = 4;
    localparam int unsigned OQ_CW      = $clog2(OQ_DEPTH + 1);

    // One command for the back end: optional write before the flush, optional
    // flush (header fill, then read-out), optional write after the flush at
    // the first byte past the fresh header slot.
    typedef struct packed {
        t_pos        wa_pos;
        t_cnt        wa_cnt;
        logic [31:0] wa_data;
        logic        flush;
        t_pos        hdr_pos;
        logic [31:0] hdr_word;
        t_pos        total;
        t_cnt        wb_cnt;
        logic [31:0] wb_data;
    } t_cmd;

    typedef struct packed {
        logic [31:0] word;
        t_cnt        bytes;
        logic        last;
    } t_oitem;

endpackage

`default_nettype wire

// ===== hdl/rrmf_fifo.sv =====
// ----------------------------------------------------------------------------
// rrmf_fifo
// Small register queue with head shown while not empty.
// ----------------------------------------------------------------------------
`default_nettype none

module rrmf_fifo #(
    parameter int unsigned W     = 8,
    parameter int unsigned DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [W-1:0]               i_data,
    output logic                            o_full,
    input  wire logic                       i_pop,
    output logic [W-1:0]                    o_data,
    output logic                            o_empty,
    output logic [$clog2(DEPTH+1)-1:0]      o_count
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rrmf_front.sv =====
// ----------------------------------------------------------------------------
// rrmf_front
// Request classifier: tracks write and header positions, turns each request
// into one back-end command, or none for a zero-count byte put.
// ----------------------------------------------------------------------------
`default_nettype none

module rrmf_front
    import rrmf_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = 256
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_W-1:0]  i_cfg_wdata,
    input  wire logic              i_push,
    input  wire logic [1:0]        i_req_type,
    input  wire logic [31:0]       i_data_word,
    input  wire logic [2:0]        i_byte_count,
    input  wire logic              i_q_full,
    output logic                   o_full,
    output logic                   o_cmd_push,
    output t_cmd                   o_cmd
);

    localparam int unsigned CAP_LIM = ((BUFFER_BYTES < 511) ? BUFFER_BYTES : 511) / 4 * 4;
    localparam t_pos        CAP_MAX = POS_W'(CAP_LIM);

    logic [CFG_W-1:0] r_cfg;
    t_pos             r_wp;
    t_pos             r_hp;
    t_pos             n_wp;
    t_pos             n_hp;

    t_pos cfg_al;
    t_pos cap_clamp;
    t_pos cap;
    t_pos room;
    t_cnt cnt_sat;
    t_cnt pre;
    t_cnt post;
    t_pos flush_end;
    t_pos hdr_len;
    logic accept;
    logic do_push;

    assign accept = i_push && !i_q_full;
    assign o_full = i_q_full;

    // Effective capacity: align down to a word, clamp, floor at two words.
    assign cfg_al    = {r_cfg[CFG_W-1:2], 2'b00};
    assign cap_clamp = (cfg_al > CAP_MAX) ? CAP_MAX : cfg_al;
    assign cap       = (cap_clamp < CAP_MIN) ? CAP_MIN : cap_clamp;
    assign room      = (r_wp >= cap) ? '0 : cap - r_wp;

    assign cnt_sat = (i_byte_count > WORD_BYTES) ? WORD_BYTES : i_byte_count;
    assign pre     = ({6'd0, cnt_sat} <= room) ? cnt_sat : room[2:0];
    assign post    = cnt_sat - pre;

    assign flush_end = (i_req_type == REQ_PUT_BYTES) ? r_wp + POS_W'(pre) : r_wp;
    assign hdr_len   = flush_end - r_hp - HDR_BYTES;

    always_comb begin
        o_cmd   = '0;
        do_push = 1'b0;
        n_wp    = r_wp;
        n_hp    = r_hp;
        case (i_req_type)
            REQ_PUT_UNIT: begin
                do_push = 1'b1;
                if (room < HDR_BYTES) begin
                    o_cmd.flush    = 1'b1;
                    o_cmd.hdr_pos  = r_hp;
                    o_cmd.hdr_word = {MARK_MORE, 22'd0, hdr_len};
                    o_cmd.total    = r_wp;
                    o_cmd.wb_cnt   = WORD_BYTES;
                    o_cmd.wb_data  = i_data_word;
                    n_wp           = HDR_BYTES + POS_W'(WORD_BYTES);
                    n_hp           = '0;
                end else begin
                    o_cmd.wa_pos  = r_wp;
                    o_cmd.wa_cnt  = WORD_BYTES;
                    o_cmd.wa_data = i_data_word;
                    n_wp          = r_wp + POS_W'(WORD_BYTES);
                end
            end
            REQ_PUT_BYTES: begin
                // Zero count: drop the request.
                if (cnt_sat != '0) begin
                    do_push       = 1'b1;
                    o_cmd.wa_pos  = r_wp;
                    o_cmd.wa_cnt  = pre;
                    o_cmd.wa_data = i_data_word;
                    if (pre != cnt_sat) begin
                        o_cmd.flush    = 1'b1;
                        o_cmd.hdr_pos  = r_hp;
                        o_cmd.hdr_word = {MARK_MORE, 22'd0, hdr_len};
                        o_cmd.total    = flush_end;
                        o_cmd.wb_cnt   = post;
                        o_cmd.wb_data  = i_data_word << {pre, 3'b000};
                        n_wp           = HDR_BYTES + POS_W'(post);
                        n_hp           = '0;
                    end else begin
                        n_wp = r_wp + POS_W'(pre);
                    end
                end
            end
            REQ_END_BUF: begin
                do_push = 1'b1;
                if (room >= HDR_BYTES) begin
                    o_cmd.wa_pos  = r_hp;
                    o_cmd.wa_cnt  = WORD_BYTES;
                    o_cmd.wa_data = {MARK_LAST, 22'd0, hdr_len};
                    n_hp          = r_wp;
                    n_wp          = r_wp + HDR_BYTES;
                end else begin
                    o_cmd.flush    = 1'b1;
                    o_cmd.hdr_pos  = r_hp;
                    o_cmd.hdr_word = {MARK_LAST, 22'd0, hdr_len};
                    o_cmd.total    = r_wp;
                    n_wp           = HDR_BYTES;
                    n_hp           = '0;
                end
            end
            REQ_END_NOW: begin
                do_push        = 1'b1;
                o_cmd.flush    = 1'b1;
                o_cmd.hdr_pos  = r_hp;
                o_cmd.hdr_word = {MARK_LAST, 22'd0, hdr_len};
                o_cmd.total    = r_wp;
                n_wp           = HDR_BYTES;
                n_hp           = '0;
            end
            default: begin
                do_push = 1'b0;
            end
        endcase
    end

    assign o_cmd_push = accept && do_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
            r_wp  <= HDR_BYTES;
            r_hp  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (accept) begin
                r_wp <= n_wp;
                r_hp <= n_hp;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rrmf_back.sv =====
// ----------------------------------------------------------------------------
// rrmf_back
// Command executor: four byte-lane banks of fragment buffer, header fill and
// word-by-word read-out into the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rrmf_back
    import rrmf_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = 256
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    input  wire logic              i_cmd_empty,
    output logic                   o_cmd_pop,
    input  wire logic [OQ_CW-1:0]  i_oq_count,
    output logic                   o_oq_push,
    output t_oitem                 o_oq_item
);

    localparam int unsigned CAP_LIM = ((BUFFER_BYTES < 511) ? BUFFER_BYTES : 511) / 4 * 4;
    localparam int unsigned ROWS    = CAP_LIM / 4;
    localparam int unsigned RW      = $clog2(ROWS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HDR  = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_WB   = 3'd3;

    logic [2:0]    r_state;
    t_cmd          r_cmd;
    logic [RW-1:0] r_row;
    logic          r_rd_valid;
    t_cnt          r_rd_cnt;
    logic          r_rd_last;
    logic [7:0]    r_rd_byte [4];

    logic          wr_en;
    t_pos          wr_pos;
    t_cnt          wr_cnt;
    logic [31:0]   wr_data;
    t_pos          tot_m1;
    logic [RW-1:0] last_row;
    t_pos          rem;
    t_cnt          rd_cnt;
    logic          credit;
    logic          rd_issue;
    logic [31:0]   rd_word;

    assign tot_m1   = r_cmd.total - 9'd1;
    assign last_row = tot_m1[RW+1:2];
    assign rem      = r_cmd.total - POS_W'({r_row, 2'b00});
    assign rd_cnt   = (rem >= HDR_BYTES) ? WORD_BYTES : rem[2:0];
    assign credit   = ({1'b0, i_oq_count} + {{OQ_CW{1'b0}}, r_rd_valid})
                      < (OQ_CW + 1)'(OQ_DEPTH);
    assign rd_issue = (r_state == S_READ) && credit;

    // Single write port shared by the pre-flush write, the header and the
    // post-flush write.
    always_comb begin
        wr_en     = 1'b0;
        wr_pos    = r_cmd.hdr_pos;
        wr_cnt    = WORD_BYTES;
        wr_data   = r_cmd.hdr_word;
        o_cmd_pop = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cmd_pop = !i_cmd_empty;
                wr_en     = !i_cmd_empty;
                wr_pos    = i_cmd.wa_pos;
                wr_cnt    = i_cmd.wa_cnt;
                wr_data   = i_cmd.wa_data;
            end
            S_HDR: begin
                wr_en = 1'b1;
            end
            S_WB: begin
                wr_en   = 1'b1;
                wr_pos  = HDR_BYTES;
                wr_cnt  = r_cmd.wb_cnt;
                wr_data = r_cmd.wb_data;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [7:0]  r_mem [ROWS];
        logic [1:0]  k;
        logic        we;
        t_pos        addr;
        logic [31:0] sh;

        // Byte k of the write lands in lane (pos + k) mod 4.
        assign k    = 2'(b) - wr_pos[1:0];
        assign we   = wr_en && ({1'b0, k} < wr_cnt);
        assign addr = wr_pos + POS_W'(k);
        assign sh   = wr_data << {k, 3'b000};

        always_ff @(posedge i_clk) begin
            if (we) begin
                r_mem[addr[RW+1:2]] <= sh[31:24];
            end
            if (rd_issue) begin
                r_rd_byte[b] <= r_mem[r_row];
            end
        end
    end

    assign rd_word = {r_rd_byte[0], r_rd_byte[1], r_rd_byte[2], r_rd_byte[3]};

    assign o_oq_push       = r_rd_valid;
    assign o_oq_item.word  = rd_word & ~(32'hFFFF_FFFF >> {r_rd_cnt, 3'b000});
    assign o_oq_item.bytes = r_rd_cnt;
    assign o_oq_item.last  = r_rd_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= rd_issue;
            case (r_state)
                S_IDLE: begin
                    if (!i_cmd_empty && i_cmd.flush) begin
                        r_state <= S_HDR;
                    end
                end
                S_HDR: begin
                    r_state <= S_READ;
                end
                S_READ: begin
                    if (rd_issue && (r_row == last_row)) begin
                        r_state <= (r_cmd.wb_cnt != '0) ? S_WB : S_IDLE;
                    end
                end
                S_WB: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_HDR) begin
            r_row <= '0;
        end else if (rd_issue) begin
            r_row <= r_row + 1'b1;
        end
        if (rd_issue) begin
            r_rd_cnt  <= rd_cnt;
            r_rd_last <= (r_row == last_row);
        end
    end

    a_oq_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> (i_oq_count < OQ_CW'(OQ_DEPTH)))
        else $error("result queue overrun");

    a_hdr_then_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HDR) |=> (r_state == S_READ))
        else $error("header fill not followed by read-out");

    a_read_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_issue && (r_row == last_row)) |=> (r_state != S_READ))
        else $error("read-out continues past final row");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_cmd_pop)
        else $error("command taken during a flush");

endmodule

`default_nettype wire

// ===== hdl/rpc_record_marking_framer.sv =====
// ----------------------------------------------------------------------------
// rpc_record_marking_framer
// Sender side of RPC record marking: buffers payload bytes behind a 4-byte
// record header and flushes the fragment as big-endian words.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Word
//  --------  ---------  -----------------  ----------------------------------
//  request   in         push / full        req_type, data_word, byte_count
//  result    out        empty / pop        out_word, out_bytes, last_of_flush
//  config    in         i_cfg_we           fragment_capacity (9 bits)
//
//  Flow: a put or a buffered end of record is done by the back end in idle,
//  so requests that cause no flush are taken one per cycle while the request
//  queue is not full. A flushing request runs its command step, the header
//  fill, the read-out (BUFFER_BYTES / 4 words at most, 64 at the default size,
//  one buffer row per cycle while the result queue has room), then a write when
//  bytes follow the flush; the request queue holds later requests meanwhile.
//  Reset: no clearing pass; the buffer is only read where written.
//  Stalls: pop held low fills the four-word result queue, which holds the
//  read-out; a full request queue raises full.
//
`default_nettype none

module rpc_record_marking_framer
    import rrmf_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = 256
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_W-1:0]  i_cfg_wdata,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [1:0]        i_req_type,
    input  wire logic [31:0]       i_data_word,
    input  wire logic [2:0]        i_byte_count,
    output logic                   empty,
    input  wire logic              pop,
    output logic [31:0]            o_out_word,
    output logic [2:0]             o_out_bytes,
    output logic                   o_last_of_flush
);

    // Front to back command path.
    t_cmd             fe_cmd;
    logic             fe_cmd_push;
    logic             cq_full;
    logic             cq_empty;
    logic             cq_pop;
    t_cmd             cq_cmd;

    // Back end to result queue.
    logic             oq_push;
    t_oitem           oq_in;
    t_oitem           oq_out;
    logic [OQ_CW-1:0] oq_count;

    rrmf_front #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_push       (push),
        .i_req_type   (i_req_type),
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .i_q_full     (cq_full),
        .o_full       (full),
        .o_cmd_push   (fe_cmd_push),
        .o_cmd        (fe_cmd)
    );

    // Decouple classification from execution so puts keep flowing while a
    // short command backlog drains.
    rrmf_fifo #(
        .W     ($bits(t_cmd)),
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_cmd_push),
        .i_data  (fe_cmd),
        .o_full  (cq_full),
        .i_pop   (cq_pop),
        .o_data  (cq_cmd),
        .o_empty (cq_empty),
        .o_count ()
    );

    rrmf_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cq_cmd),
        .i_cmd_empty (cq_empty),
        .o_cmd_pop   (cq_pop),
        .i_oq_count  (oq_count),
        .o_oq_push   (oq_push),
        .o_oq_item   (oq_in)
    );

    // Result queue: the back end only reads a row when a slot is free here.
    rrmf_fifo #(
        .W     ($bits(t_oitem)),
        .DEPTH (OQ_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (oq_push),
        .i_data  (oq_in),
        .o_full  (),
        .i_pop   (pop),
        .o_data  (oq_out),
        .o_empty (empty),
        .o_count (oq_count)
    );

    assign o_out_word      = oq_out.word;
    assign o_out_bytes     = oq_out.bytes;
    assign o_last_of_flush = oq_out.last;

endmodule

`default_nettype wire
